[sv/tfe_pkg.sv]
package tfe_pkg;

  // Operation carried by an input beat.
  localparam logic OP_CONVERT = 1'b0;
  localparam logic OP_PAL_WRITE = 1'b1;

  // Pixel format register codes. The reserved code decodes as indexed.
  localparam logic [1:0] FMT_RGB565 = 2'd0;
  localparam logic [1:0] FMT_ARGB1555 = 2'd1;
  localparam logic [1:0] FMT_INDEXED = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_PIXEL_FORMAT = 1'b0;
  localparam logic CFG_COLOR_KEY = 1'b1;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [7:0] ALPHA_CLEAR = 8'h00;

  typedef struct packed {
    logic        op;
    logic [15:0] texel;
    logic [7:0]  entry_index;
    logic [7:0]  entry_red;
    logic [7:0]  entry_green;
    logic [7:0]  entry_blue;
  } tfe_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } tfe_out_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } tfe_rgb_t;

  // Result of the direct expansion, with a flag that the colour must come
  // from the palette instead.
  typedef struct packed {
    tfe_out_t rgba;
    logic     indexed;
  } tfe_expand_t;

endpackage

[sv/tfe_palette.sv]
module tfe_palette #(
  parameter int Entries = 256
) (
  input  logic                                    clk_i,
  input  logic                                    wr_en_i,
  input  logic [(Entries > 1 ? $clog2(Entries) : 1)-1:0] wr_addr_i,
  input  tfe_pkg::tfe_rgb_t                       wr_data_i,
  input  logic                                    rd_en_i,
  input  logic [(Entries > 1 ? $clog2(Entries) : 1)-1:0] rd_addr_i,
  output tfe_pkg::tfe_rgb_t                       rd_data_o
);
  import tfe_pkg::*;

  tfe_rgb_t mem_q [Entries];
  tfe_rgb_t rd_data_q;

  // Write and read are never for the same beat, so a read always sees the
  // contents left by the previous clock edge.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[sv/tfe_expand.sv]
module tfe_expand (
  input  logic [1:0]           pixel_format_i,
  input  logic                 color_key_en_i,
  input  logic [15:0]          texel_i,
  output tfe_pkg::tfe_expand_t res_o
);
  import tfe_pkg::*;

  // Rounded widening of a 5-bit channel: (v * 527 + 23) >> 6.
  function automatic logic [7:0] widen5(input logic [4:0] v);
    logic [13:0] prod;
    prod = 14'(v) * 14'd527 + 14'd23;
    return prod[13:6];
  endfunction

  // Rounded widening of a 6-bit channel: (v * 259 + 33) >> 6.
  function automatic logic [7:0] widen6(input logic [5:0] v);
    logic [13:0] prod;
    prod = 14'(v) * 14'd259 + 14'd33;
    return prod[13:6];
  endfunction

  always_comb begin
    res_o = '0;
    case (pixel_format_i)
      FMT_RGB565: begin
        res_o.rgba.red   = widen5(texel_i[15:11]);
        res_o.rgba.green = widen6(texel_i[10:5]);
        res_o.rgba.blue  = widen5(texel_i[4:0]);
        res_o.rgba.alpha = ALPHA_OPAQUE;
      end
      FMT_ARGB1555: begin
        res_o.rgba.red   = widen5(texel_i[14:10]);
        res_o.rgba.green = widen5(texel_i[9:5]);
        res_o.rgba.blue  = widen5(texel_i[4:0]);
        res_o.rgba.alpha = texel_i[15] ? ALPHA_OPAQUE : ALPHA_CLEAR;
      end
      default: begin
        // Indexed, and the reserved code along with it.
        res_o.indexed    = 1'b1;
        res_o.rgba.alpha = (texel_i[7:0] == 8'd0 && color_key_en_i) ? ALPHA_CLEAR
                                                                     : ALPHA_OPAQUE;
      end
    endcase
  end

endmodule

[sv/texel_format_expander_core.sv]
// Texel format expander. Each convert beat on the input channel yields one
// RGBA8888 beat on the output channel; a palette-write beat loads one 24-bit
// entry of the palette and yields nothing. The block takes one beat per clock
// cycle while the output side keeps up. A result passes through the synchronous
// palette read (and the registered direct expansion beside it), then the
// output register. The output register decouples the two sides, so a new
// texel is still taken while a result waits if the first stage is empty. The
// pixel format and colour key registers should only be written while no beat
// is in flight. Palette entries hold no reset value; reading one that has
// never been written returns whatever the memory holds. Indexes at or above
// PALETTE_ENTRIES read as black and are not written.
module texel_format_expander_core #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tfe_pkg::tfe_in_t  in_beat_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tfe_pkg::tfe_out_t out_beat_o,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [1:0]        cfg_data_i
);
  import tfe_pkg::*;

  localparam int AddrW = PALETTE_ENTRIES > 1 ? $clog2(PALETTE_ENTRIES) : 1;

  // Configuration registers.
  logic [1:0] pixel_format_q, pixel_format_d;
  logic       color_key_en_q, color_key_en_d;

  always_comb begin
    pixel_format_d = pixel_format_q;
    color_key_en_d = color_key_en_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PIXEL_FORMAT: pixel_format_d = cfg_data_i;
        CFG_COLOR_KEY:    color_key_en_d = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Handshake. The output register loads whenever it is empty or being
  // drained; the first stage advances whenever it is empty or can move on.
  logic in_accept, out_load;
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;

  assign out_load   = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || out_load;
  assign in_accept  = in_valid_i && in_ready_o;

  // Palette access. Both addresses are range-checked against the depth.
  logic     wr_in_range, rd_in_range;
  logic     pal_we, pal_re;
  tfe_rgb_t pal_wdata, pal_rdata;

  assign wr_in_range = {1'b0, in_beat_i.entry_index} < 9'(PALETTE_ENTRIES);
  assign rd_in_range = {1'b0, in_beat_i.texel[7:0]} < 9'(PALETTE_ENTRIES);
  assign pal_we      = in_accept && (in_beat_i.op == OP_PAL_WRITE) && wr_in_range;
  assign pal_re      = in_accept && (in_beat_i.op == OP_CONVERT);
  assign pal_wdata   = '{red:   in_beat_i.entry_red,
                         green: in_beat_i.entry_green,
                         blue:  in_beat_i.entry_blue};

  tfe_palette #(
    .Entries (PALETTE_ENTRIES)
  ) u_palette (
    .clk_i     (clk_i),
    .wr_en_i   (pal_we),
    .wr_addr_i (in_beat_i.entry_index[AddrW-1:0]),
    .wr_data_i (pal_wdata),
    .rd_en_i   (pal_re),
    .rd_addr_i (in_beat_i.texel[AddrW-1:0]),
    .rd_data_o (pal_rdata)
  );

  // Direct expansion, registered alongside the palette read.
  tfe_expand_t exp_res;

  tfe_expand u_expand (
    .pixel_format_i (pixel_format_q),
    .color_key_en_i (color_key_en_q),
    .texel_i        (in_beat_i.texel),
    .res_o          (exp_res)
  );

  tfe_expand_t s1_res_q;
  logic        s1_in_range_q;

  assign s1_valid_d  = in_ready_o ? pal_re : s1_valid_q;
  assign out_valid_d = out_load ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i) begin
    if (pal_re) begin
      s1_res_q      <= exp_res;
      s1_in_range_q <= rd_in_range;
    end
  end

  // Merge the palette colour in for indexed texels.
  tfe_out_t out_beat_q, out_beat_d;

  always_comb begin
    out_beat_d = s1_res_q.rgba;
    if (s1_res_q.indexed) begin
      if (s1_in_range_q) begin
        out_beat_d.red   = pal_rdata.red;
        out_beat_d.green = pal_rdata.green;
        out_beat_d.blue  = pal_rdata.blue;
      end else begin
        out_beat_d.red   = 8'd0;
        out_beat_d.green = 8'd0;
        out_beat_d.blue  = 8'd0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && s1_valid_q) begin
      out_beat_q <= out_beat_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_format_q <= FMT_RGB565;
      color_key_en_q <= 1'b1;
      s1_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      pixel_format_q <= pixel_format_d;
      color_key_en_q <= color_key_en_d;
      s1_valid_q     <= s1_valid_d;
      out_valid_q    <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

endmodule

[tb/texel_format_expander_checker.sv]
module texel_format_expander_checker #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  tfe_pkg::tfe_in_t  in_beat_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  tfe_pkg::tfe_out_t out_beat_i,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [1:0]        cfg_data_i,
  output int                mismatch_count_o,
  output int                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import tfe_pkg::*;

  localparam int FIVE_MUL = 527;
  localparam int FIVE_ADD = 23;
  localparam int SIX_MUL  = 259;
  localparam int SIX_ADD  = 33;
  localparam int REPORT_LIMIT = 10;

  logic [1:0] fmt_q    = FMT_RGB565;
  logic       key_en_q = 1'b1;
  tfe_rgb_t   palette_shadow [256];
  tfe_out_t   rgba_due [$];
  int         errors = 0;

  function automatic logic [7:0] widen_five(logic [4:0] v);
    int acc;
    acc = int'(v) * FIVE_MUL + FIVE_ADD;
    return 8'(acc >> 6);
  endfunction

  function automatic logic [7:0] widen_six(logic [5:0] v);
    int acc;
    acc = int'(v) * SIX_MUL + SIX_ADD;
    return 8'(acc >> 6);
  endfunction

  // Colour of one texel under the current format and key setting.
  function automatic tfe_out_t predict_rgba(logic [15:0] texel);
    tfe_out_t   rgba;
    logic [7:0] idx;
    idx = texel[7:0];
    if ((fmt_q & FMT_INDEXED) != 2'b00) begin
      if (int'(idx) < PALETTE_ENTRIES) begin
        rgba.red   = palette_shadow[idx].red;
        rgba.green = palette_shadow[idx].green;
        rgba.blue  = palette_shadow[idx].blue;
      end else begin
        rgba.red   = '0;
        rgba.green = '0;
        rgba.blue  = '0;
      end
      rgba.alpha = (idx == 8'd0 && key_en_q) ? ALPHA_CLEAR : ALPHA_OPAQUE;
    end else if (fmt_q == FMT_ARGB1555) begin
      rgba.red   = widen_five(texel[14:10]);
      rgba.green = widen_five(texel[9:5]);
      rgba.blue  = widen_five(texel[4:0]);
      rgba.alpha = texel[15] ? ALPHA_OPAQUE : ALPHA_CLEAR;
    end else begin
      rgba.red   = widen_five(texel[15:11]);
      rgba.green = widen_six(texel[10:5]);
      rgba.blue  = widen_five(texel[4:0]);
      rgba.alpha = ALPHA_OPAQUE;
    end
    return rgba;
  endfunction

  task automatic note_mismatch(string what, tfe_out_t want, tfe_out_t got);
    if (errors < REPORT_LIMIT) begin
      $display("%0t: %s: expected r=%02h g=%02h b=%02h a=%02h,",
               $realtime, what, want.red, want.green, want.blue, want.alpha,
               " got r=%02h g=%02h b=%02h a=%02h",
               got.red, got.green, got.blue, got.alpha);
    end
    errors++;
  endtask

  always @(posedge clk_i) begin
    tfe_out_t want;
    if (!rst_ni) begin
      fmt_q    = FMT_RGB565;
      key_en_q = 1'b1;
      rgba_due.delete();
    end else begin
      // Results are checked before this edge's input is taken, so a result can
      // never be matched against a beat accepted in the same cycle.
      if (out_valid_i && out_ready_i) begin
        if (rgba_due.size() == 0) begin
          note_mismatch("result with no beat waiting", '0, out_beat_i);
        end else begin
          want = rgba_due.pop_front();
          if (out_beat_i.red !== want.red || out_beat_i.green !== want.green ||
              out_beat_i.blue !== want.blue || out_beat_i.alpha !== want.alpha) begin
            note_mismatch("wrong colour", want, out_beat_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (in_beat_i.op == OP_PAL_WRITE) begin
          if (int'(in_beat_i.entry_index) < PALETTE_ENTRIES) begin
            palette_shadow[in_beat_i.entry_index].red   = in_beat_i.entry_red;
            palette_shadow[in_beat_i.entry_index].green = in_beat_i.entry_green;
            palette_shadow[in_beat_i.entry_index].blue  = in_beat_i.entry_blue;
          end
        end else begin
          rgba_due.push_back(predict_rgba(in_beat_i.texel));
        end
      end
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_PIXEL_FORMAT) begin
          fmt_q = cfg_data_i;
        end else begin
          key_en_q = cfg_data_i[0];
        end
      end
    end
    pending_o        = rgba_due.size();
    mismatch_count_o = errors;
  end

endmodule

[tb/texel_format_expander_core_tb.sv]
// Stimulus and verdict for the texel format expander. A checker beside the
// block watches both channels and the register port, predicts every result
// beat and compares it; this module only makes traffic and reads the checker's
// failure and pending counts.
module texel_format_expander_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tfe_pkg::*;

  localparam int PALETTE_ENTRIES = 256;
  // The reserved format code, which the block must treat as indexed.
  localparam logic [1:0] FMT_RESERVED = 2'd3;
  localparam int RESET_CYCLES = 12;
  // Spare idle cycles before a register write. A palette write takes effect
  // at the edge that accepts it, so this is margin only.
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES = 6;
  localparam int HOLD_OFF_CYCLES = 250;
  localparam int STALL_LIMIT = 3000;
  localparam int RANDOM_PHASES = 12;
  localparam int BEATS_PER_PHASE = 38;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  tfe_in_t    in_beat_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  tfe_out_t   out_beat_o;
  logic       cfg_we_i = 1'b0;
  logic       cfg_index_i = CFG_PIXEL_FORMAT;
  logic [1:0] cfg_data_i = FMT_RGB565;

  int mismatches;
  int pending;
  int quiet_cycles = 0;

  // When set, neither side inserts gaps, so the block runs at full rate unless a receiver hold-off is requested.
  bit steady_phase = 1'b0;
  // Raised by the stimulus to make the receiver back off for a long stretch.
  bit hold_off_req = 1'b0;

  // Palette entries that have been loaded since reset. Indexed reads are only
  // ever aimed at these, since an unloaded entry holds no defined colour.
  bit   entry_loaded [256];
  logic [7:0] loaded_list [$];

  always #5ns clk_i = ~clk_i;

  texel_format_expander_core #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_beat_i  (in_beat_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_beat_o (out_beat_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  texel_format_expander_checker #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .in_beat_i       (in_beat_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_beat_i      (out_beat_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .mismatch_count_o(mismatches),
    .pending_o       (pending)
  );

  // The watchdog ends the run if no beat moves on either channel for too long.
  // The long receiver hold-off and the longest gaps stay well inside the limit.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Mostly back-to-back or short gaps, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady_phase || roll < 55) begin
      return 0;
    end else if (roll < 90) begin
      return $urandom_range(1, 3);
    end else if (roll < 98) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  // Offers one beat and returns once it has been taken. Called and left at a
  // falling edge. Valid is only lowered when a gap precedes the beat, so it is
  // never dropped and raised again at the same edge.
  task automatic push_beat(input tfe_in_t beat);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_beat_i  <= beat;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // A convert beat; the palette fields carry noise that the block must ignore.
  task automatic send_texel(input logic [15:0] texel);
    tfe_in_t beat;
    beat.op          = OP_CONVERT;
    beat.texel       = texel;
    beat.entry_index = 8'($urandom);
    beat.entry_red   = 8'($urandom);
    beat.entry_green = 8'($urandom);
    beat.entry_blue  = 8'($urandom);
    push_beat(beat);
  endtask

  // A palette write; its texel field is noise as well.
  task automatic load_entry(input logic [7:0] idx, input logic [7:0] red,
                            input logic [7:0] green, input logic [7:0] blue);
    tfe_in_t beat;
    beat.op          = OP_PAL_WRITE;
    beat.texel       = 16'($urandom);
    beat.entry_index = idx;
    beat.entry_red   = red;
    beat.entry_green = green;
    beat.entry_blue  = blue;
    push_beat(beat);
    if (!entry_loaded[idx]) begin
      entry_loaded[idx] = 1'b1;
      loaded_list.push_back(idx);
    end
  endtask

  // Index zero is favoured so that the colour key is hit often.
  function automatic logic [7:0] pick_loaded();
    if ($urandom_range(0, 7) == 0) begin
      return 8'd0;
    end
    return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
  endfunction

  // Registers are only written with the block idle: input held off, every
  // expected result delivered, and the SETTLE_CYCLES margin after that.
  task automatic set_reg(input logic index, input logic [1:0] value);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_index_i <= index;
    cfg_data_i  <= value;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Receiver: random stalls, plus one long hold-off on request so that the
  // output register and the pipeline fill up and the input is back-pressured.
  initial begin
    int gap;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_off_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          out_ready_i <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
  end

  initial begin
    logic [1:0] fmt;
    logic       key;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part. Reset leaves the block in RGB565 with keying on.
    // Black, white, each channel alone at full scale, and the lowest bit of
    // every channel.
    send_texel(16'h0000);
    send_texel(16'hFFFF);
    send_texel(16'hF800);
    send_texel(16'h07E0);
    send_texel(16'h001F);
    send_texel(16'h0821);

    // ARGB1555: the alpha bit alone, everything but alpha, all set, red alone.
    set_reg(CFG_PIXEL_FORMAT, FMT_ARGB1555);
    send_texel(16'h8000);
    send_texel(16'h7FFF);
    send_texel(16'hFFFF);
    send_texel(16'h7C00);

    // Load the first and last palette entries and one in the middle.
    load_entry(8'd0, 8'hFF, 8'h00, 8'h80);
    load_entry(8'd255, 8'h00, 8'hFF, 8'h7F);
    load_entry(8'd128, 8'h12, 8'h34, 8'h56);

    // Indexed with keying on: index zero is transparent, the upper texel
    // bits must not disturb the lookup.
    set_reg(CFG_PIXEL_FORMAT, FMT_INDEXED);
    send_texel(16'h0000);
    send_texel(16'hFF00);
    send_texel(16'h00FF);
    send_texel(16'h5A80);

    // Keying off: index zero becomes opaque.
    set_reg(CFG_COLOR_KEY, 2'b00);
    send_texel(16'h0000);
    send_texel(16'h3380);

    // The reserved format code behaves as indexed, with and without keying.
    set_reg(CFG_PIXEL_FORMAT, FMT_RESERVED);
    send_texel(16'hFFFF);
    send_texel(16'h0000);
    set_reg(CFG_COLOR_KEY, 2'b01);
    send_texel(16'h0000);

    // Random part. Each phase picks a format and key setting, then streams a
    // mix of palette writes and converts. The first eight phases walk every
    // format with keying off and then on; the rest are drawn at random.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase % 4)
        0: fmt = FMT_RGB565;
        1: fmt = FMT_ARGB1555;
        2: fmt = FMT_INDEXED;
        default: fmt = FMT_RESERVED;
      endcase
      if (phase >= 8) begin
        fmt = 2'($urandom_range(0, 3));
      end
      key = (phase < 8) ? phase[2] : 1'($urandom_range(0, 1));
      set_reg(CFG_PIXEL_FORMAT, fmt);
      set_reg(CFG_COLOR_KEY, {1'b0, key});
      steady_phase = ($urandom_range(0, 3) == 0);
      // One phase starves the output side while input keeps coming.
      if (phase == 5) begin
        hold_off_req = 1'b1;
      end
      for (int n = 0; n < BEATS_PER_PHASE; n++) begin
        if ($urandom_range(0, 3) == 0) begin
          load_entry(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        end else if ((fmt & FMT_INDEXED) != 2'b00) begin
          send_texel({8'($urandom), pick_loaded()});
        end else begin
          send_texel(16'($urandom));
        end
      end
    end
    steady_phase = 1'b0;

    // Let every result drain, then allow the pipeline a DRAIN_CYCLES margin in
    // case something unexpected is still on its way out.
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[sim.f]
sv/tfe_pkg.sv
sv/tfe_palette.sv
sv/tfe_expand.sv
sv/texel_format_expander_core.sv
tb/texel_format_expander_checker.sv
tb/texel_format_expander_core_tb.sv
